@@ hw/rtl/cc20_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the quarter-round step for the ChaCha20 block.
// ----------------------------------------------------------------------------
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] blk_t;

  // Input queue between the front and the back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Round engine: two half quarter-round steps per half round, 20 half rounds
  localparam int RND_CYCLES = 40;
  localparam int RND_CNT_W  = $clog2(RND_CYCLES);

  localparam int BLK_WORDS = 16;
  localparam int POS_W     = 7;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY01    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY23    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY45    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY67    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NONCE01  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_NONCE2   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_CTR_INIT = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       last;
  } q_item_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT
  } back_state_t;

  // Half of a quarter round: first half rotates by 16/12, second by 8/7
  function automatic qr_t qr_step(qr_t q, logic second);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    qr_t   r;
    a = q.a + q.b;
    d = q.d ^ a;
    d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
    c = q.c + d;
    b = q.b ^ c;
    b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

endpackage

@@ hw/rtl/cc20_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_front
// Input side: accepts items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cc20_front import cc20_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  q_item_t in_item,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                push;

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

@@ hw/rtl/cc20_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_core
// ChaCha20 round engine: four quarter-round lanes, half a quarter round per
// cycle through the 10 double rounds, then the input block added back.
// ----------------------------------------------------------------------------
module cc20_core import cc20_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  blk_t init_blk,
  output logic done,
  output blk_t ks_blk
);

  blk_t                 w_r;
  blk_t                 w_nxt;
  logic [RND_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 second;
  logic                 diag;

  assign second = cnt_r[0];
  assign diag   = cnt_r[1];
  assign done   = done_r;

  always_comb begin
    qr_t q;
    qr_t r;
    w_nxt = w_r;
    for (int i = 0; i < 4; i++) begin
      if (diag) begin
        q.a = w_r[i];
        q.b = w_r[4 + ((i + 1) % 4)];
        q.c = w_r[8 + ((i + 2) % 4)];
        q.d = w_r[12 + ((i + 3) % 4)];
      end else begin
        q.a = w_r[i];
        q.b = w_r[4 + i];
        q.c = w_r[8 + i];
        q.d = w_r[12 + i];
      end
      r = qr_step(q, second);
      if (diag) begin
        w_nxt[i]                  = r.a;
        w_nxt[4 + ((i + 1) % 4)]  = r.b;
        w_nxt[8 + ((i + 2) % 4)]  = r.c;
        w_nxt[12 + ((i + 3) % 4)] = r.d;
      end else begin
        w_nxt[i]      = r.a;
        w_nxt[4 + i]  = r.b;
        w_nxt[8 + i]  = r.c;
        w_nxt[12 + i] = r.d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < BLK_WORDS; i++) begin
      ks_blk[i] = w_r[i] + init_blk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r <= init_blk;
    end else if (busy_r) begin
      w_r <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == RND_CNT_W'(RND_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("round engine started while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without finishing the rounds");
`endif

endmodule

@@ hw/rtl/cc20_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_back
// Back end: configuration registers, block counter, keystream buffer and
// byte position; starts the round engine when a block is needed and XORs
// queued bytes with the keystream into the output register.
// ----------------------------------------------------------------------------
module cc20_back import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]           cfg_wdata,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data,
  output logic                  out_last
);

  logic [63:0]      key_r [4];
  logic [63:0]      nonce01_r;
  word_t            nonce2_r;
  word_t            ctr_init_r;
  word_t            ctr_r;
  word_t            ks_r [BLK_WORDS];
  logic [POS_W-1:0] pos_r;
  logic             first_r;
  logic             head_done_r;
  back_state_t      state_r;
  back_state_t      state_nxt;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  blk_t             init_blk;
  blk_t             core_ks;
  logic             core_start;
  logic             core_done;
  logic             need_blk;
  logic             out_free;
  logic             emit;
  logic             new_blk;
  logic [7:0]       ks_byte;
  word_t            ks_word;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_comb begin
    init_blk[0]  = SIGMA0;
    init_blk[1]  = SIGMA1;
    init_blk[2]  = SIGMA2;
    init_blk[3]  = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_blk[4 + 2 * i]     = key_r[i][31:0];
      init_blk[4 + 2 * i + 1] = key_r[i][63:32];
    end
    init_blk[12] = ctr_r;
    init_blk[13] = nonce01_r[31:0];
    init_blk[14] = nonce01_r[63:32];
    init_blk[15] = nonce2_r;
  end

  cc20_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .init_blk (init_blk),
    .done     (core_done),
    .ks_blk   (core_ks)
  );

  // A head item needs a fresh block once per item, not again after it is made
  assign need_blk = !head_done_r && (q_item.restart || first_r || pos_r[POS_W-1]);
  assign out_free = !out_valid_r || out_ready;
  assign ks_word  = ks_r[pos_r[5:2]];
  assign ks_byte  = ks_word[{pos_r[1:0], 3'b000} +: 8];

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    core_start = 1'b0;
    emit       = 1'b0;
    new_blk    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (need_blk) begin
            new_blk   = 1'b1;
            state_nxt = ST_LOAD;
          end else if (out_free) begin
            emit  = 1'b1;
            q_pop = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        core_start = 1'b1;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce01_r  <= '0;
      nonce2_r   <= '0;
      ctr_init_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KEY01:    key_r[0]   <= cfg_wdata;
        CFG_KEY23:    key_r[1]   <= cfg_wdata;
        CFG_KEY45:    key_r[2]   <= cfg_wdata;
        CFG_KEY67:    key_r[3]   <= cfg_wdata;
        CFG_NONCE01:  nonce01_r  <= cfg_wdata;
        CFG_NONCE2:   nonce2_r   <= cfg_wdata[31:0];
        CFG_CTR_INIT: ctr_init_r <= cfg_wdata[31:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      for (int i = 0; i < BLK_WORDS; i++) begin
        ks_r[i] <= core_ks[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= q_item.data ^ ks_byte;
      out_last_r <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      pos_r       <= POS_W'(64);
      first_r     <= 1'b1;
      head_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (new_blk) begin
        ctr_r <= (q_item.restart || first_r) ? ctr_init_r : ctr_r + 1'b1;
      end
      if (core_done) begin
        pos_r       <= '0;
        first_r     <= 1'b0;
        head_done_r <= 1'b1;
      end else if (emit) begin
        pos_r       <= pos_r + 1'b1;
        head_done_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_blk_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |=> pos_r == '0 && head_done_r && !first_r)
    else $error("new block did not rewind the byte position");
  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && !need_blk && state_r == ST_IDLE)
    else $error("item consumed without a usable keystream byte");
  a_no_emit_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> !emit)
    else $error("byte emitted while the block is being made");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

@@ hw/rtl/chacha20_stream_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 byte-stream cipher with a write-only configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   Write key, nonce and starting counter through cfg_* while no item is in
//   flight. Send one byte per in_* item; in_tuser set restarts the keystream
//   at the starting counter. Each item yields one out_* item carrying the byte
//   XOR the keystream byte, with tlast copied.
//   An accepted byte passes the input queue and then the output register
//   before out_tvalid; the first byte of a block also waits while the back
//   end starts the round engine, the engine runs its rounds and the block,
//   with the input added back, is registered into the keystream buffer.
//   Throughput: one byte per cycle inside a block while out_tready is high;
//   each new block stalls the stream while the single round engine of four
//   quarter-round lanes makes it. A two-entry input queue and an output
//   register decouple the channels; when out_tready is low the result holds,
//   the queue fills, then in_tready drops. Reset clears the queue, the output
//   and the configuration registers; the first byte after reset starts a
//   block from the start counter. There is no clearing pass.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,  // [7:0] data_in
  input  logic                  in_tuser,  // [0] restart
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata, // [7:0] data_out
  output logic                  out_tlast
);

  q_item_t in_item;
  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;

  assign in_item.data    = in_tdata;
  assign in_item.restart = in_tuser;
  assign in_item.last    = in_tlast;

  cc20_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  cc20_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

@@ bench/tb_chacha20_stream_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher_top
// Self-checking bench for the ChaCha20 byte-stream cipher. A keystream
// tracker class mirrors the key, nonce, counter and current block, predicts
// each ciphered byte and checks results in order. Traffic mixes short and
// long messages, restarts, counter wrap, config changes between phases,
// random back-pressure on the result channel and random gaps on the input.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_top;
  import cc20_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 60;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 135;
  localparam int N_PHASES       = 8;
  localparam longint TIMEOUT_NS = 5_000_000;

  // index 7 has no register behind it
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef logic [63:0] reg_set_t [7];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  class keystream_tracker;
    logic [31:0]  key_w[8];
    logic [31:0]  nonce_w[3];
    logic [31:0]  ctr_init;
    logic [31:0]  blk_ctr;
    logic [31:0]  ks_words[16];
    logic [31:0]  mix[16];
    logic [6:0]   pos;
    bit           need_first;
    cipher_byte_t expected_bytes[$];
    int           errors;
    int           n_in;
    int           n_out;
    int           n_blocks;
    int           n_restarts;
    int           n_wraps;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      foreach (nonce_w[i]) nonce_w[i] = '0;
      foreach (ks_words[i]) ks_words[i] = '0;
      ctr_init   = '0;
      blk_ctr    = '0;
      pos        = 7'd64;
      need_first = 1'b1;
      errors     = 0;
      n_in       = 0;
      n_out      = 0;
      n_blocks   = 0;
      n_restarts = 0;
      n_wraps    = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void make_block();
      logic [31:0] init[16];
      int r;
      init[0] = SIGMA0;
      init[1] = SIGMA1;
      init[2] = SIGMA2;
      init[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
      init[12] = blk_ctr;
      for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
      for (int i = 0; i < 16; i++) mix[i] = init[i];
      for (r = 0; r < 10; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + init[i];
      pos = '0;
      n_blocks++;
    endfunction

    // register writes only change what the next block is built from
    function void note_config(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY01: begin
          key_w[0] = val[31:0];
          key_w[1] = val[63:32];
        end
        CFG_KEY23: begin
          key_w[2] = val[31:0];
          key_w[3] = val[63:32];
        end
        CFG_KEY45: begin
          key_w[4] = val[31:0];
          key_w[5] = val[63:32];
        end
        CFG_KEY67: begin
          key_w[6] = val[31:0];
          key_w[7] = val[63:32];
        end
        CFG_NONCE01: begin
          nonce_w[0] = val[31:0];
          nonce_w[1] = val[63:32];
        end
        CFG_NONCE2:   nonce_w[2] = val[31:0];
        CFG_CTR_INIT: ctr_init = val[31:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] d, logic rs, logic lst);
      logic [31:0]  w;
      logic [7:0]   ks;
      cipher_byte_t e;
      if (rs || need_first) begin
        if (rs) n_restarts++;
        blk_ctr    = ctr_init;
        need_first = 1'b0;
        make_block();
      end else if (pos[6]) begin
        blk_ctr = blk_ctr + 32'd1;
        if (blk_ctr == '0) n_wraps++;
        make_block();
      end
      w      = ks_words[pos[5:2]];
      ks     = w[pos[1:0]*8 +: 8];
      pos    = pos + 7'd1;
      e.data = d ^ ks;
      e.last = lst;
      expected_bytes.push_back(e);
      n_in++;
    endfunction

    function void check_byte(logic [7:0] d, logic lst);
      cipher_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: data_out %h out_last %b", d, lst);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      n_out++;
      if (d !== e.data) begin
        $error("data_out mismatch: expected %h, actual %h", e.data, d);
        errors++;
      end
      if (lst !== e.last) begin
        $error("out_last mismatch: expected %b, actual %b", e.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [63:0]           cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;  // [7:0] data_in
  logic                  in_tuser;  // [0] restart
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata; // [7:0] data_out
  logic                  out_tlast;

  keystream_tracker sb;
  bit sender_gaps;
  bit calm;
  bit hold_req;
  int n_settings;

  localparam logic [CFG_ADDR_W-1:0] REG_IDX [7] = '{
    CFG_KEY01, CFG_KEY23, CFG_KEY45, CFG_KEY67, CFG_NONCE01, CFG_NONCE2, CFG_CTR_INIT
  };

  chacha20_stream_cipher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_chacha20_stream_cipher_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic rs, input logic lst);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= rs;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(d, rs, lst);
    if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // caller lowers cfg_we after the last write of a group
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.note_config(idx, val);
  endtask

  task automatic program_setting(input reg_set_t vals, input bit some_only);
    for (int k = 0; k < 7; k++) begin
      if (!some_only || $urandom_range(0, 1) == 1) write_reg(REG_IDX[k], vals[k]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed messages (restart on the first byte of most, last on final),
  // some noise with restart and last scattered
  task automatic run_traffic(input int n_items, input int first_len);
    int  sent;
    int  len;
    int  k;
    bit  noisy;
    sent = 0;
    while (sent < n_items) begin
      noisy = ($urandom_range(0, 6) == 0);
      if (sent == 0 && first_len > 0) begin
        noisy = 1'b0;
        len   = first_len;
      end else if (noisy) begin
        len = $urandom_range(1, 20);
      end else if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(65, 200);
      end else begin
        len = $urandom_range(1, 64);
      end
      for (k = 0; k < len; k++) begin
        if (noisy)
          send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        else
          send_byte(8'($urandom), k == 0 && (sent == 0 || $urandom_range(0, 4) != 0),
                    k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    reg_set_t vals;
    sb          = new();
    sender_gaps = 1'b1;
    calm        = 1'b0;
    hold_req    = 1'b0;
    n_settings  = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: first byte builds a block without a restart
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    // restart in the middle of a block
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    wait_idle();

    // unmapped index is dropped; upper bits of 32-bit registers are dropped
    write_reg(CFG_UNMAPPED, '1);
    write_reg(CFG_NONCE2, 64'hFFFF_FFFF_1234_5678);
    write_reg(CFG_CTR_INIT, 64'hDEAD_BEEF_0000_0003);
    cfg_we <= 1'b0;
    // partly used block stays in use until a restart
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h96, 1'b0, 1'b1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: foreach (vals[i]) vals[i] = '1;  // counter at max: wraps in the first message
        1: begin
          vals[0] = 64'h0706_0504_0302_0100;
          vals[1] = 64'h0f0e_0d0c_0b0a_0908;
          vals[2] = 64'h1716_1514_1312_1110;
          vals[3] = 64'h1f1e_1d1c_1b1a_1918;
          vals[4] = 64'h4a00_0000_0900_0000;
          vals[5] = 64'h0;
          vals[6] = 64'h1;
        end
        3: foreach (vals[i]) vals[i] = '0;
        default: foreach (vals[i]) vals[i] = {$urandom, $urandom};
      endcase
      program_setting(vals, ph >= 4 && ph <= 6 && $urandom_range(0, 1) == 1);
      sender_gaps = (ph != 2);
      calm        = (ph == N_PHASES - 1);
      if (ph == 2) hold_req = 1'b1;
      run_traffic(PHASE_ITEMS, (ph == 0) ? 150 : 0);
    end

    wait_idle();
    $display("%0d bytes ciphered and %0d checked over %0d register settings",
             sb.n_in, sb.n_out, n_settings);
    $display("%0d keystream blocks, %0d restarts, %0d counter wraps",
             sb.n_blocks, sb.n_restarts, sb.n_wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_chacha20_stream_cipher_top passed");
    end else begin
      $display("tb_chacha20_stream_cipher_top failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_front.sv
hw/rtl/cc20_core.sv
hw/rtl/cc20_back.sv
hw/rtl/chacha20_stream_cipher_top.sv
bench/tb_chacha20_stream_cipher_top.sv
